@@ src/assert_macros.svh @@
// Assertion helpers shared by the parser and queue RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define PNGTXT_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pngtxt assertion failed");
// Next-cycle implication, checked outside reset
`define PNGTXT_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pngtxt assertion failed");
`else
`define PNGTXT_ASSERT_IMP(name, clk, rstn, ante, cons)
`define PNGTXT_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

@@ src/pngtxt_pkg.sv @@
package pngtxt_pkg;

    // Result status codes
    localparam logic [2:0] ST_BYTE   = 3'd0;
    localparam logic [2:0] ST_FINAL  = 3'd1;
    localparam logic [2:0] ST_NONE   = 3'd2;
    localparam logic [2:0] ST_BADSIG = 3'd3;
    localparam logic [2:0] ST_TRUNC  = 3'd4;

    // Chunk type tags, first byte in the top byte
    localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    localparam logic [3:0] KEYWORD_LEN = 4'd11;

    // Default depth of the result queue
    localparam int QUEUE_DEPTH = 4;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_SIG  = 8'b0000_0001,
        PH_LEN  = 8'b0000_0010,
        PH_TYPE = 8'b0000_0100,
        PH_KEY  = 8'b0000_1000,
        PH_TEXT = 8'b0001_0000,
        PH_DATA = 8'b0010_0000,
        PH_CRC  = 8'b0100_0000,
        PH_DONE = 8'b1000_0000
    } pngtxt_phase_t;

    // One queued result; last is derived from status downstream
    typedef struct packed {
        logic [7:0] text_byte;
        logic [2:0] status;
    } pngtxt_result_t;

    // First four bytes of the PNG signature
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h89;
            2'd1:    b = 8'h50;
            2'd2:    b = 8'h4E;
            default: b = 8'h47;
        endcase
        return b;
    endfunction

    // "Description"
    function automatic logic [7:0] keyword_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h44;
            4'd1:    b = 8'h65;
            4'd2:    b = 8'h73;
            4'd3:    b = 8'h63;
            4'd4:    b = 8'h72;
            4'd5:    b = 8'h69;
            4'd6:    b = 8'h70;
            4'd7:    b = 8'h74;
            4'd8:    b = 8'h69;
            4'd9:    b = 8'h6F;
            4'd10:   b = 8'h6E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ src/png_text_chunk_extractor.sv @@
// A result beat passes through the result queue and then the output register before it is offered on m_.
// Throughput: one input byte per cycle while the result queue is not full.
// The result queue (QUEUE_DEPTH entries) lets input continue while m_tready is low.
// Reset: synchronous, aresetn low clears the parser, the queue and the output valid.
// After each file's final byte the parser returns to its reset state by itself.
module png_text_chunk_extractor #(
    parameter int QUEUE_DEPTH = pngtxt_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,    // end_of_file
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] text_byte
    output logic       m_tlast,    // last
    output logic [2:0] m_tuser     // [2:0] status
);

    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       q_not_empty;
    pngtxt_pkg::pngtxt_result_t push_data;
    pngtxt_pkg::pngtxt_result_t pop_data;

    pngtxt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    pngtxt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    pngtxt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

@@ src/pngtxt_front.sv @@
`include "assert_macros.svh"

// Chunk parser: takes one byte per beat and classifies it, emitting at most
// one result per byte into the queue.
module pngtxt_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic                        s_tlast,   // end_of_file
    input  logic                        queue_full,
    output logic                        push,
    output pngtxt_pkg::pngtxt_result_t  push_data
);

    pngtxt_pkg::pngtxt_phase_t phase_reg, phase_next;
    logic [31:0] byte_cnt_reg, byte_cnt_next;
    logic [31:0] chunk_len_reg, chunk_len_next;
    logic [23:0] type_reg, type_next;
    logic [3:0]  key_idx_reg, key_idx_next;

    logic        fire;
    logic [31:0] cnt_inc;
    logic [31:0] type_shift;
    logic        len_hit;
    logic        res_valid;
    logic [7:0]  res_byte;
    logic [2:0]  res_status;

    assign s_tready   = !queue_full;
    assign fire       = s_tvalid && s_tready;
    assign cnt_inc    = byte_cnt_reg + 32'd1;
    assign type_shift = {type_reg, s_tdata};
    assign len_hit    = (cnt_inc == chunk_len_reg);

    // Next state and result for the byte on the input
    always_comb begin
        phase_next     = phase_reg;
        byte_cnt_next  = byte_cnt_reg;
        chunk_len_next = chunk_len_reg;
        type_next      = type_reg;
        key_idx_next   = key_idx_reg;
        res_valid      = 1'b0;
        res_byte       = 8'h00;
        res_status     = pngtxt_pkg::ST_BYTE;

        case (phase_reg)
            pngtxt_pkg::PH_SIG: begin
                if (!byte_cnt_reg[2] &&
                    s_tdata != pngtxt_pkg::sig_byte(byte_cnt_reg[1:0])) begin
                    res_valid  = 1'b1;
                    res_status = pngtxt_pkg::ST_BADSIG;
                    phase_next = pngtxt_pkg::PH_DONE;
                end else if (byte_cnt_reg[2:0] == 3'd7) begin
                    phase_next     = pngtxt_pkg::PH_LEN;
                    byte_cnt_next  = '0;
                    chunk_len_next = '0;
                end else begin
                    byte_cnt_next = cnt_inc;
                end
            end
            pngtxt_pkg::PH_LEN: begin
                chunk_len_next = {chunk_len_reg[23:0], s_tdata};
                if (byte_cnt_reg[1:0] == 2'd3) begin
                    phase_next    = pngtxt_pkg::PH_TYPE;
                    byte_cnt_next = '0;
                    type_next     = '0;
                end else begin
                    byte_cnt_next = cnt_inc;
                end
            end
            pngtxt_pkg::PH_TYPE: begin
                type_next = type_shift[23:0];
                if (byte_cnt_reg[1:0] == 2'd3) begin
                    byte_cnt_next = '0;
                    if (type_shift == pngtxt_pkg::TYPE_IEND) begin
                        res_valid  = 1'b1;
                        res_status = pngtxt_pkg::ST_NONE;
                        phase_next = pngtxt_pkg::PH_DONE;
                    end else if (chunk_len_reg == '0) begin
                        phase_next = pngtxt_pkg::PH_CRC;
                    end else if (type_shift == pngtxt_pkg::TYPE_TEXT) begin
                        key_idx_next = '0;
                        phase_next   = pngtxt_pkg::PH_KEY;
                    end else begin
                        phase_next = pngtxt_pkg::PH_DATA;
                    end
                end else begin
                    byte_cnt_next = cnt_inc;
                end
            end
            pngtxt_pkg::PH_KEY: begin
                byte_cnt_next = cnt_inc;
                if (key_idx_reg < pngtxt_pkg::KEYWORD_LEN) begin
                    key_idx_next = key_idx_reg + 4'd1;
                    if (len_hit) begin
                        phase_next    = pngtxt_pkg::PH_CRC;
                        byte_cnt_next = '0;
                    end else if (s_tdata != pngtxt_pkg::keyword_byte(key_idx_reg)) begin
                        phase_next = pngtxt_pkg::PH_DATA;
                    end
                end else if (s_tdata == 8'h00) begin
                    // null after a full keyword match: text follows, or empty text ends the search
                    if (len_hit) begin
                        res_valid  = 1'b1;
                        res_status = pngtxt_pkg::ST_NONE;
                        phase_next = pngtxt_pkg::PH_DONE;
                    end else begin
                        phase_next = pngtxt_pkg::PH_TEXT;
                    end
                end else if (len_hit) begin
                    phase_next    = pngtxt_pkg::PH_CRC;
                    byte_cnt_next = '0;
                end else begin
                    phase_next = pngtxt_pkg::PH_DATA;
                end
            end
            pngtxt_pkg::PH_TEXT: begin
                byte_cnt_next = cnt_inc;
                res_valid     = 1'b1;
                res_byte      = s_tdata;
                if (len_hit) begin
                    res_status = pngtxt_pkg::ST_FINAL;
                    phase_next = pngtxt_pkg::PH_DONE;
                end
            end
            pngtxt_pkg::PH_DATA: begin
                if (len_hit) begin
                    phase_next    = pngtxt_pkg::PH_CRC;
                    byte_cnt_next = '0;
                end else begin
                    byte_cnt_next = cnt_inc;
                end
            end
            pngtxt_pkg::PH_CRC: begin
                if (byte_cnt_reg[1:0] == 2'd3) begin
                    phase_next     = pngtxt_pkg::PH_LEN;
                    byte_cnt_next  = '0;
                    chunk_len_next = '0;
                end else begin
                    byte_cnt_next = cnt_inc;
                end
            end
            default: begin
            end
        endcase

        // End of file: close the run if no final result went out yet, and rearm the parser
        if (s_tlast) begin
            if (!(res_valid && res_status != pngtxt_pkg::ST_BYTE)) begin
                res_byte = 8'h00;
                if (phase_next == pngtxt_pkg::PH_TEXT) begin
                    res_valid  = 1'b1;
                    res_status = pngtxt_pkg::ST_TRUNC;
                end else if (phase_next == pngtxt_pkg::PH_SIG) begin
                    res_valid  = 1'b1;
                    res_status = pngtxt_pkg::ST_BADSIG;
                end else if (phase_next != pngtxt_pkg::PH_DONE) begin
                    res_valid  = 1'b1;
                    res_status = pngtxt_pkg::ST_NONE;
                end
            end
            phase_next     = pngtxt_pkg::PH_SIG;
            byte_cnt_next  = '0;
            chunk_len_next = '0;
            type_next      = '0;
            key_idx_next   = '0;
        end
    end

    // Parser state, updated on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= pngtxt_pkg::PH_SIG;
            byte_cnt_reg  <= '0;
            chunk_len_reg <= '0;
            type_reg      <= '0;
            key_idx_reg   <= '0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            byte_cnt_reg  <= byte_cnt_next;
            chunk_len_reg <= chunk_len_next;
            type_reg      <= type_next;
            key_idx_reg   <= key_idx_next;
        end
    end

    assign push                = fire && res_valid;
    assign push_data.text_byte = res_byte;
    assign push_data.status    = res_status;

    // A final beat always leaves the parser in its start state
    `PNGTXT_ASSERT_NXT(a_eof_rearms, aclk, aresetn, fire && s_tlast,
        phase_reg == pngtxt_pkg::PH_SIG && byte_cnt_reg == 32'd0)
    // Once done, only the final beat can produce a result
    `PNGTXT_ASSERT_IMP(a_done_silent, aclk, aresetn,
        fire && phase_reg == pngtxt_pkg::PH_DONE && !s_tlast, !push)

endmodule

@@ src/pngtxt_fifo.sv @@
`include "assert_macros.svh"

// Small result queue between the parser and the output stage.
module pngtxt_fifo #(
    parameter int DEPTH = pngtxt_pkg::QUEUE_DEPTH   // 2 or more
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  pngtxt_pkg::pngtxt_result_t  push_data,
    output logic                        full,
    input  logic                        pop,
    output logic                        not_empty,
    output pngtxt_pkg::pngtxt_result_t  pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pngtxt_pkg::pngtxt_result_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PNGTXT_ASSERT_IMP(a_no_overflow, aclk, aresetn, push, !full)
    `PNGTXT_ASSERT_IMP(a_no_underflow, aclk, aresetn, pop, not_empty)
    `PNGTXT_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL)

endmodule

@@ src/pngtxt_back.sv @@
// Output stage: pulls results from the queue into the master register and
// forms the last flag from the status.
module pngtxt_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_not_empty,
    input  pngtxt_pkg::pngtxt_result_t  q_data,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] text_byte
    output logic                        m_tlast,   // last
    output logic [2:0]                  m_tuser    // [2:0] status
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [2:0] status_reg;

    // Load when the register is empty or being drained
    assign pop = q_not_empty && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset; every status but a plain text byte closes the run
    always_ff @(posedge aclk) begin
        if (pop) begin
            byte_reg   <= q_data.text_byte;
            status_reg <= q_data.status;
            last_reg   <= (q_data.status != pngtxt_pkg::ST_BYTE);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = status_reg;

endmodule
